[hdl/mlp_inference_argmax_core_macros.svh]
// Assertion macros used by the MLP core.
`ifndef MLP_INFERENCE_ARGMAX_CORE_MACROS_SVH
`define MLP_INFERENCE_ARGMAX_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hdl/mia_pkg.sv]
// Package: constants, types and the sigmoid table of the MLP core.
`default_nettype none
package mia_pkg;
  localparam int MaxLayers  = 4;
  localparam int MaxNeurons = 64;
  localparam int SigEntries = 256;
  localparam int NW  = $clog2(MaxNeurons);
  localparam int WDepth = (MaxLayers - 1) * MaxNeurons * MaxNeurons;
  localparam int BDepth = (MaxLayers - 1) * MaxNeurons;
  // Input layer plus two buffers that hidden layers alternate between.
  localparam int ADepth = 3 * MaxNeurons;
  localparam int WAW = $clog2(WDepth);
  localparam int BAW = $clog2(BDepth);
  localparam int AAW = $clog2(ADepth);
  localparam int SIW = $clog2(SigEntries);
  localparam int ACCW = 32 + NW;

  localparam logic [1:0] OpLoadW = 2'd0;
  localparam logic [1:0] OpLoadB = 2'd1;
  localparam logic [1:0] OpLoadA = 2'd2;
  localparam logic [1:0] OpRun   = 2'd3;

  localparam logic [2:0] CfgNumLayers = 3'd0;
  localparam logic [2:0] CfgInSize    = 3'd1;
  localparam logic [2:0] CfgH1Size    = 3'd2;
  localparam logic [2:0] CfgH2Size    = 3'd3;
  localparam logic [2:0] CfgH3Size    = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  layer_sel;
    logic [5:0]  row;
    logic [5:0]  col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  class_index;
    logic [12:0] best_value;
  } out_item_t;

  // Control from sequencer to datapath.
  typedef struct packed {
    logic clr;     // start a new neuron sum
    logic mac;     // accumulate product of registered operands
  } dp_ctl_t;

  typedef logic [SigEntries-1:0][15:0] sig_tab_t;

  // Shift-and-subtract quotient, only evaluated while elaborating the table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int n = 63; n >= 0; n--) begin
      r = {r[62:0], num[n]};
      if (r >= den) begin
        r = r - den;
        q[n] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid entry, elaborated at compile time.
  function automatic logic [15:0] sig_entry(input int unsigned i);
    logic [63:0] one, a, b, u, y, y2, e, d, r;
    logic nonneg;
    one = 64'd1 << 30;
    a = 64'(16 * i);
    b = 64'(8 * SigEntries);
    nonneg = a >= b;
    u = nonneg ? a - b : b - a;
    y = udiv64(u << 30, 64'(SigEntries) * 64'd1024);
    y2 = y * y;
    e = one - y + (y2 >> 31) - udiv64(((y2 >> 30) * y) >> 30, 64'd6);
    for (int k = 0; k < 10; k++) e = (e * e) >> 30;
    d = one + e;
    if (nonneg) r = udiv64((64'd1 << 42) + (d >> 1), d);
    else        r = udiv64(64'd4096 * e + (d >> 1), d);
    return r[15:0];
  endfunction

  // Build the whole lookup table.
  function automatic sig_tab_t sig_table_init();
    sig_tab_t t;
    for (int unsigned n = 0; n < SigEntries; n++) t[n] = sig_entry(n);
    return t;
  endfunction

  localparam sig_tab_t SigTab = sig_table_init();
endpackage
`default_nettype wire

[hdl/mia_if.sv]
// Valid/ready channel interface carrying one payload item.
`default_nettype none
interface mia_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/mia_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module mia_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/mia_datapath.sv]
// Shared multiply-accumulate unit with bias add, saturation and sigmoid lookup.
`default_nettype none
module mia_datapath import mia_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_ctl_t     ctl_i,
  input  wire logic [15:0] w_i,
  input  wire logic [15:0] a_i,
  input  wire logic [15:0] b_i,
  output logic      [15:0] sig_o
);
  logic signed [31:0]     prod_q;
  logic signed [ACCW-1:0] acc_q, acc_d;
  logic signed [ACCW-1:0] z;
  logic        [15:0]     zsat;
  logic        [SIW-1:0]  idx;

  // Register the product, then accumulate it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      prod_q <= $signed(w_i) * $signed(a_i);
      acc_q  <= acc_d;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr)      acc_d = '0;
    else if (ctl_i.mac) acc_d = acc_q + ACCW'(prod_q);
  end

  // Floor-shift by 12, add bias, saturate to 16 bits, index the table.
  always_comb begin
    z = (acc_q >>> 12) + ACCW'($signed(b_i));
    if (z > ACCW'(32767))       zsat = 16'h7fff;
    else if (z < -ACCW'(32768)) zsat = 16'h8000;
    else                        zsat = z[15:0];
    idx = SIW'({~zsat[15], zsat[14:0]} >> (16 - SIW));
    sig_o = SigTab[idx];
  end
endmodule
`default_nettype wire

[hdl/mlp_inference_argmax_core.sv]
// MLP inference core: load items fill stores, a run item drives a sequencer over one MAC.
//
// Usage:
//   in_if  : valid/ready channel of items {operation, layer_sel, row, col, value}.
//   out_if : valid/ready channel of results {class_index, best_value}, one per run.
//   cfg    : write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) for the layer count and
//            the four layer sizes; write it only while no run is in flight.
// Loads (weight, bias, input activation) are taken one per cycle while the sequencer is
// idle and give no result. A run walks every layer; for each neuron the shared multiplier
// reads one weight and one activation per cycle from the RAMs, then the states StDrn1,
// StDrn2 and StFin drain the read and multiply stages and finish the neuron. The result
// becomes valid as the run ends, and the input is held off until then; the single MAC
// and the RAM read port set the run length. The argmax is kept on the fly as output
// neurons finish. The result sits in an output register; while it is not taken the core
// accepts further loads but holds off the next run.
// Reset clears the sequencer, sets the layer count to 3 and the sizes to 64, 32, 10,
// 1; store contents are undefined until written.
`default_nettype none
`include "mlp_inference_argmax_core_macros.svh"
module mlp_inference_argmax_core import mia_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mia_if.sink        in_if,
  mia_if.source      out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_wdata_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMac  = 3'd1;
  localparam logic [2:0] StDrn1 = 3'd2;
  localparam logic [2:0] StDrn2 = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  // Activation RAM regions.
  localparam logic [1:0] RgInput = 2'd0;
  localparam logic [1:0] RgHidA  = 2'd1;
  localparam logic [1:0] RgHidB  = 2'd2;

  logic [2:0] cfg_layers_q;
  logic [6:0] sz_q [4];
  logic [2:0] st_q, st_d;
  logic [1:0] k_q, k_d;           // source layer
  logic [NW-1:0] j_q, j_d, i_q, i_d;
  logic [NW-1:0] best_i_q, best_i_d;
  logic [12:0] best_v_q, best_v_d;
  logic ov_q, ov_d;
  out_item_t od_q, od_d;
  logic mac1_q, mac2_q;

  logic [2:0] layers;
  logic [NW:0] szc [4];
  logic [NW-1:0] nsrc, ndst;
  logic last_layer;
  logic [1:0] src_rg, dst_rg;
  in_item_t it;
  logic acc_in;
  dp_ctl_t ctl;
  logic [15:0] w_rd, a_rd, b_rd, sig;

  // RAM ports
  logic           w_we, b_we, a_we;
  logic [WAW-1:0] w_wa, w_ra;
  logic [BAW-1:0] b_wa, b_ra;
  logic [AAW-1:0] a_wa, a_ra;
  logic [15:0]    a_wd;

  assign it = in_if.data;
  assign in_if.ready = (st_q == StIdle) && !(it.operation == OpRun && ov_q);
  assign acc_in = in_if.valid && in_if.ready;
  assign out_if.valid = ov_q;
  assign out_if.data  = od_q;

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_layers_q <= 3'd3;
      sz_q[0] <= 7'd64; sz_q[1] <= 7'd32; sz_q[2] <= 7'd10; sz_q[3] <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumLayers: cfg_layers_q <= cfg_wdata_i[2:0];
        CfgInSize:    sz_q[0] <= cfg_wdata_i;
        CfgH1Size:    sz_q[1] <= cfg_wdata_i;
        CfgH2Size:    sz_q[2] <= cfg_wdata_i;
        CfgH3Size:    sz_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Saturate sizes and the layer count.
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      if (sz_q[n] == 7'd0) szc[n] = (NW+1)'(1);
      else if (sz_q[n] > 7'(MaxNeurons)) szc[n] = (NW+1)'(MaxNeurons);
      else szc[n] = sz_q[n][NW:0];
    end
    if (cfg_layers_q < 3'd2) layers = 3'd2;
    else if (cfg_layers_q > 3'(MaxLayers)) layers = 3'(MaxLayers);
    else layers = cfg_layers_q;
    nsrc = NW'(szc[k_q] - 1'b1);
    ndst = NW'(szc[k_q + 2'd1] - 1'b1);
    last_layer = (3'(k_q) + 3'd2) == layers;
  end

  // Read the input layer first, then alternate the hidden buffers so that a layer
  // never overwrites its own source or the input layer.
  always_comb begin
    if (k_q == 2'd0) src_rg = RgInput;
    else             src_rg = k_q[0] ? RgHidA : RgHidB;
    dst_rg = k_q[0] ? RgHidB : RgHidA;
  end

  // Memory addressing.
  always_comb begin
    w_we = acc_in && it.operation == OpLoadW && it.layer_sel < 2'(MaxLayers - 1);
    w_wa = WAW'({it.layer_sel, it.row, it.col});
    w_ra = WAW'({k_q, j_q, i_q});
    b_we = acc_in && it.operation == OpLoadB && it.layer_sel < 2'(MaxLayers - 1);
    b_wa = BAW'({it.layer_sel, it.row});
    b_ra = BAW'({k_q, j_q});
    a_ra = AAW'({src_rg, i_q});
    if (st_q == StFin) begin
      a_we = 1'b1;
      a_wa = AAW'({dst_rg, j_q});
      a_wd = sig;
    end else begin
      a_we = acc_in && it.operation == OpLoadA;
      a_wa = AAW'({RgInput, it.row});
      a_wd = it.value;
    end
  end

  mia_ram #(.Width(16), .Depth(WDepth)) u_wram (.clk_i, .we_i(w_we), .waddr_i(w_wa),
    .wdata_i(it.value), .raddr_i(w_ra), .rdata_o(w_rd));
  mia_ram #(.Width(16), .Depth(BDepth)) u_bram (.clk_i, .we_i(b_we), .waddr_i(b_wa),
    .wdata_i(it.value), .raddr_i(b_ra), .rdata_o(b_rd));
  mia_ram #(.Width(16), .Depth(ADepth)) u_aram (.clk_i, .we_i(a_we), .waddr_i(a_wa),
    .wdata_i(a_wd), .raddr_i(a_ra), .rdata_o(a_rd));

  // Valid MAC operands in the cycle after issue; product registered after that.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac1_q <= 1'b0; mac2_q <= 1'b0;
    end else begin
      mac1_q <= (st_q == StMac);
      mac2_q <= mac1_q;
    end
  end

  // Clear the sum once a neuron is finished.
  assign ctl.clr = (st_q == StFin);
  assign ctl.mac = mac2_q;

  mia_datapath u_dp (.clk_i, .rst_ni, .ctl_i(ctl), .w_i(w_rd), .a_i(a_rd), .b_i(b_rd),
    .sig_o(sig));

  // Sequencer.
  always_comb begin
    st_d = st_q; k_d = k_q; j_d = j_q; i_d = i_q;
    best_i_d = best_i_q; best_v_d = best_v_q;
    ov_d = ov_q; od_d = od_q;
    if (out_if.valid && out_if.ready) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (acc_in && it.operation == OpRun) begin
          st_d = StMac; k_d = '0; j_d = '0; i_d = '0;
        end
      end
      StMac: begin
        if (i_q == nsrc) st_d = StDrn1;
        else i_d = i_q + 1'b1;
      end
      StDrn1: st_d = StDrn2;
      StDrn2: st_d = StFin;
      StFin: begin
        i_d = '0;
        if (last_layer && (j_q == '0 || 13'(sig) > best_v_q)) begin
          best_v_d = 13'(sig); best_i_d = j_q;
        end
        st_d = StMac;
        if (j_q == ndst) begin
          j_d = '0;
          if (last_layer) begin
            st_d = StIdle;
            ov_d = 1'b1;
            od_d.class_index = 6'((j_q == '0 || 13'(sig) > best_v_q) ? j_q : best_i_q);
            od_d.best_value  = (j_q == '0 || 13'(sig) > best_v_q) ? 13'(sig) : best_v_q;
          end else begin
            k_d = k_q + 1'b1;
          end
        end else j_d = j_q + 1'b1;
      end
      default: st_d = StIdle;
    endcase
  end

  // Advance the sequencer and hold the pending result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; k_q <= '0; j_q <= '0; i_q <= '0;
      best_i_q <= '0; best_v_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; k_q <= k_d; j_q <= j_d; i_q <= i_d;
      best_i_q <= best_i_d; best_v_q <= best_v_d; ov_q <= ov_d;
    end
  end
  always_ff @(posedge clk_i) od_q <= od_d;

  // Checks.
  `MLP_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, st_q != StIdle, !in_if.ready, "busy accept")
  `MLP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid,
    "result dropped")
  `MLP_ASSERT_IMP(a_run_blocked, clk_i, rst_ni, ov_q && it.operation == OpRun, !in_if.ready,
    "run while result pending")
endmodule
`default_nettype wire
